@@ sv/vdib_pkg.sv @@
package vdib_pkg;
   localparam int KEY_WORDS = 8;
   localparam int WORD_W = 32;
   localparam int KEY_W = KEY_WORDS * WORD_W;
   localparam int IDX_OUT_W = 8;
   localparam logic [WORD_W-1:0] ABS_MASK = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] EXP_ALL_ONES = 32'h7F80_0000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RESP
   } state_type;

   // Float equality of two single-precision bit patterns.
   function automatic logic word_equal(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
      logic [WORD_W-1:0] ma;
      logic [WORD_W-1:0] mb;
      ma = a & ABS_MASK;
      mb = b & ABS_MASK;
      if (ma > EXP_ALL_ONES || mb > EXP_ALL_ONES) begin
         return 1'b0;
      end
      if (ma == '0 && mb == '0) begin
         return 1'b1;
      end
      return a == b;
   endfunction

   function automatic logic key_equal(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
      logic eq;
      eq = 1'b1;
      for (int w = 0; w < KEY_WORDS; w++) begin
         eq = eq & word_equal(a[w*WORD_W +: WORD_W], b[w*WORD_W +: WORD_W]);
      end
      return eq;
   endfunction
endpackage

@@ sv/vdib_cell.sv @@
// One table entry: holds a key, compares the broadcast search key.
module vdib_cell
   import vdib_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             load_prev,
   input  logic             load_here,
   input  logic [KEY_W-1:0] key,
   output logic             used_out,
   output logic             hit
);
   logic             used_ff, used_in;
   logic [KEY_W-1:0] key_ff;

   // Fill marker: next free cell is the first one whose predecessor is used
   always_comb begin
      used_in = used_ff;
      if (clear) begin
         used_in = 1'b0;
      end else if (load_here) begin
         used_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_here) begin
         key_ff <= key;
      end
   end

   assign used_out = used_ff;
   assign hit      = used_ff & !clear & key_equal(key_ff, key) & !load_prev;
endmodule

@@ sv/vertex_dedup_index_builder.sv @@
// Vertex deduplication table built as a row of TABLE_DEPTH entry cells. Each
// cell keeps one key and compares the broadcast vertex in parallel; a priority
// pick over the hit flags yields the lowest matching index, and the first
// unused cell takes a new key. A vertex is latched at its transfer, compared
// and inserted in the next cycle, and its result is registered. The next
// vertex is taken in the cycle after the result has been transferred, so no
// new vertex is accepted until the result of the last one has been taken.
// start_of_mesh clears the fill flags of all entries but entry zero, which
// takes the new key at once; no clearing pass follows reset.
module vertex_dedup_index_builder
   import vdib_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_start_of_mesh,
   input  logic [WORD_W-1:0]    req_pos_x,
   input  logic [WORD_W-1:0]    req_pos_y,
   input  logic [WORD_W-1:0]    req_pos_z,
   input  logic [WORD_W-1:0]    req_nrm_x,
   input  logic [WORD_W-1:0]    req_nrm_y,
   input  logic [WORD_W-1:0]    req_nrm_z,
   input  logic [WORD_W-1:0]    req_tex_u,
   input  logic [WORD_W-1:0]    req_tex_v,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [IDX_OUT_W-1:0] rsp_vertex_index,
   output logic                 rsp_is_new,
   output logic                 rsp_table_full
);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   state_type state_ff, state_in;
   logic [KEY_W-1:0]     key_ff;
   logic                 som_ff;
   logic [TABLE_DEPTH-1:0] used, hit, load;
   logic [IDX_OUT_W-1:0] idx_ff, idx_in;
   logic                 new_ff, new_in, full_ff, full_in;
   logic [IDX_W-1:0]     hit_idx, free_idx;
   logic                 any_hit, any_free;

   // Capture the vertex
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         key_ff <= {req_tex_v, req_tex_u, req_nrm_z, req_nrm_y, req_nrm_x,
                    req_pos_z, req_pos_y, req_pos_x};
         som_ff <= req_start_of_mesh;
      end
   end

   // Cell row
   for (genvar c = 0; c < TABLE_DEPTH; c++) begin : g_cell
      logic prev_used;
      if (c == 0) begin : g_first
         assign prev_used = 1'b1;
      end else begin : g_rest
         assign prev_used = used[c-1] & !som_ff;
      end
      assign load[c] = (state_ff == ST_SEARCH) && !any_hit && prev_used
                       && (som_ff || !used[c]);
      vdib_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .clear     (state_ff == ST_SEARCH && som_ff && c != 0),
         .load_prev (1'b0),
         .load_here (load[c]),
         .key       (key_ff),
         .used_out  (used[c]),
         .hit       (hit[c])
      );
   end

   // Lowest hit and first free entry
   always_comb begin
      any_hit  = 1'b0;
      any_free = 1'b0;
      hit_idx  = '0;
      free_idx = '0;
      for (int c = TABLE_DEPTH - 1; c >= 0; c--) begin
         if (hit[c] && !som_ff) begin
            any_hit = 1'b1;
            hit_idx = IDX_W'(c);
         end
         if (load[c]) begin
            any_free = 1'b1;
            free_idx = IDX_W'(c);
         end
      end
   end

   // Control and result register
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      new_in   = new_ff;
      full_in  = full_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            state_in = ST_RESP;
            if (any_hit) begin
               idx_in  = IDX_OUT_W'(hit_idx);
               new_in  = 1'b0;
               full_in = 1'b0;
            end else if (any_free) begin
               idx_in  = IDX_OUT_W'(free_idx);
               new_in  = 1'b1;
               full_in = 1'b0;
            end else begin
               idx_in  = '0;
               new_in  = 1'b0;
               full_in = 1'b1;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      new_ff  <= new_in;
      full_ff <= full_in;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = (state_ff == ST_RESP);
   assign rsp_vertex_index = idx_ff;
   assign rsp_is_new       = new_ff;
   assign rsp_table_full   = full_ff;

`ifndef ASSERT_OFF
   a_one_load: assert property (@(posedge clock) disable iff (reset) $onehot0(load))
      else $error("more than one entry loaded");
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_new && rsp_table_full))
      else $error("new and full together");
   a_full_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> rsp_vertex_index == '0)
      else $error("full result with nonzero index");
   a_som_first: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && som_ff) |-> load[0])
      else $error("mesh start did not store at entry zero");
`endif
endmodule
